// ===== rtl/core/jst_pkg.sv =====
// Shared types, constants and lookup functions for the JSON stream tokenizer.
package jst_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int IW = 24;
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_DEPTH);

  localparam logic [1:0] RK_PAYLOAD = 2'd0;
  localparam logic [1:0] RK_TOKEN = 2'd1;
  localparam logic [1:0] RK_OK = 2'd2;
  localparam logic [1:0] RK_ERROR = 2'd3;

  localparam logic [3:0] TK_OBJ_OPEN = 4'd0;
  localparam logic [3:0] TK_OBJ_CLOSE = 4'd1;
  localparam logic [3:0] TK_ARR_OPEN = 4'd2;
  localparam logic [3:0] TK_ARR_CLOSE = 4'd3;
  localparam logic [3:0] TK_STRING = 4'd4;
  localparam logic [3:0] TK_NUMBER = 4'd5;
  localparam logic [3:0] TK_TRUE = 4'd6;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_UNTERM = 3'd2;
  localparam logic [2:0] ERR_ESCAPE = 3'd3;
  localparam logic [2:0] ERR_LITERAL = 3'd4;
  localparam logic [2:0] ERR_UNBAL = 3'd5;
  localparam logic [2:0] ERR_UNCLOSED = 3'd6;
  localparam logic [2:0] ERR_DEEP = 3'd7;

  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_STRING = 3'd1;
  localparam logic [2:0] M_ESCAPE = 3'd2;
  localparam logic [2:0] M_HEX = 3'd3;
  localparam logic [2:0] M_NUMBER = 3'd4;
  localparam logic [2:0] M_LITERAL = 3'd5;

  typedef struct packed {
    logic [1:0] rk;
    logic [3:0] tk;
    logic [7:0] pay;
    logic [IW-1:0] pos;
    logic close;
    logic [2:0] err;
    logic two;
  } rec_t;

  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      2'd1: begin
        unique case (i)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (i)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (i)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] k);
    return (k == 2'd1) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic is_num_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || b == "-" || b == "+" || b == "." ||
           b == "e" || b == "E";
  endfunction

endpackage

// ===== rtl/core/json_stream_tokenizer.sv =====
// JSON byte-stream tokenizer with bracket matching through an opener-index stack RAM.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | sink      | in_valid / in_stall   | data_byte, end_of_stream
//  out     | source    | out_valid / out_stall | record_kind .. error_code, last_of_run
//
// One byte per clock while in_stall is low; a byte is decoded in the cycle it is
// taken and its records appear from the result register in the next cycle. The
// first byte of a number produces two records, which stalls the input until the
// second record is taken. Close tokens read the opener stack RAM; the data lands
// with the record. rst is synchronous; the stack RAM is not cleared. out_stall
// holds the result register and backs up into in_stall.
module json_stream_tokenizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_stream,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            record_kind,
  output logic [3:0]            token_kind,
  output logic [7:0]            payload_byte,
  output logic [jst_pkg::IW-1:0] token_position,
  output logic [jst_pkg::IW-1:0] opener_position,
  output logic [jst_pkg::IW-1:0] span_length,
  output logic [2:0]            error_code,
  output logic                  last_of_run
);

  logic [2:0] mode, mode_next;
  logic [1:0] lit_kind, lit_kind_next;
  logic [2:0] lit_count, lit_count_next;
  logic lit_bad, lit_bad_next;
  logic [2:0] hex_count, hex_count_next;
  logic [jst_pkg::IW-1:0] counter, counter_next;
  logic [jst_pkg::DEPTH_W-1:0] depth, depth_next;
  logic draining, draining_next;

  logic [jst_pkg::IW-1:0] stack_mem [jst_pkg::MAX_DEPTH];
  logic [jst_pkg::IW-1:0] rd_data;

  jst_pkg::rec_t res, job;
  logic res_valid, job_valid, phase;
  logic push, pop, accept, job_done;
  logic eos, do_between, bad, do_err, doc_rst;
  logic [2:0] err_code;
  logic [7:0] esc_c;
  logic esc_ok, esc_u;
  logic [1:0] k;
  logic [2:0] cnt_inc;
  logic [jst_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [jst_pkg::IW:0] span_raw;

  assign eos = end_of_stream || (data_byte == 8'h00);
  assign job_done = job_valid && !out_stall && (!job.two || phase);
  assign in_stall = job_valid && !job_done;
  assign accept = in_valid && !in_stall;
  assign k = (lit_kind == 2'd3) ? 2'd0 : lit_kind;
  assign cnt_inc = lit_count + 3'd1;
  assign wr_addr = depth[jst_pkg::ADDR_W-1:0];
  assign rd_addr = jst_pkg::ADDR_W'(depth - jst_pkg::DEPTH_W'(1));

  always_comb begin
    esc_c = 8'h00;
    esc_ok = 1'b1;
    esc_u = 1'b0;
    unique case (data_byte)
      "\"": esc_c = "\"";
      "\\": esc_c = "\\";
      "/": esc_c = "/";
      "b": esc_c = 8'd8;
      "f": esc_c = 8'd12;
      "n": esc_c = 8'd10;
      "r": esc_c = 8'd13;
      "t": esc_c = 8'd9;
      "u": esc_u = 1'b1;
      default: esc_ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_next = mode;
    lit_kind_next = lit_kind;
    lit_count_next = lit_count;
    lit_bad_next = lit_bad;
    hex_count_next = hex_count;
    counter_next = counter;
    depth_next = depth;
    draining_next = draining;
    res = '0;
    res_valid = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    do_between = 1'b0;
    do_err = 1'b0;
    err_code = jst_pkg::ERR_NONE;
    doc_rst = 1'b0;
    bad = lit_bad;

    if (draining) begin
      doc_rst = eos;
    end else begin
      unique case (mode)
        jst_pkg::M_STRING: begin
          if (eos) begin
            do_err = 1'b1;
            err_code = jst_pkg::ERR_UNTERM;
          end else if (data_byte == "\\") begin
            mode_next = jst_pkg::M_ESCAPE;
          end else if (data_byte == "\"") begin
            mode_next = jst_pkg::M_BETWEEN;
          end else begin
            res_valid = 1'b1;
            res.rk = jst_pkg::RK_PAYLOAD;
            res.tk = jst_pkg::TK_STRING;
            res.pay = data_byte;
          end
        end
        jst_pkg::M_ESCAPE: begin
          if (eos || !esc_ok) begin
            do_err = 1'b1;
            err_code = jst_pkg::ERR_ESCAPE;
          end else if (esc_u) begin
            hex_count_next = 3'd4;
            mode_next = jst_pkg::M_HEX;
          end else begin
            res_valid = 1'b1;
            res.rk = jst_pkg::RK_PAYLOAD;
            res.tk = jst_pkg::TK_STRING;
            res.pay = esc_c;
            mode_next = jst_pkg::M_STRING;
          end
        end
        jst_pkg::M_HEX: begin
          if (eos) begin
            do_err = 1'b1;
            err_code = jst_pkg::ERR_UNTERM;
          end else begin
            if (hex_count != 3'd0) hex_count_next = hex_count - 3'd1;
            if (hex_count <= 3'd1) mode_next = jst_pkg::M_STRING;
          end
        end
        jst_pkg::M_LITERAL: begin
          if (eos) begin
            do_err = 1'b1;
            err_code = jst_pkg::ERR_LITERAL;
          end else begin
            bad = lit_bad || (lit_count >= jst_pkg::lit_len(k)) ||
                  (jst_pkg::lit_char(k, lit_count) != data_byte);
            lit_bad_next = bad;
            lit_count_next = cnt_inc;
            if (cnt_inc >= jst_pkg::lit_len(k)) begin
              lit_count_next = 3'd0;
              lit_bad_next = 1'b0;
              mode_next = jst_pkg::M_BETWEEN;
              if (bad) begin
                do_err = 1'b1;
                err_code = jst_pkg::ERR_LITERAL;
              end else begin
                res_valid = 1'b1;
                res.rk = jst_pkg::RK_TOKEN;
                res.tk = jst_pkg::TK_TRUE + {2'b00, k};
                res.pos = counter;
                if (counter != jst_pkg::IDX_MAX) counter_next = counter + 1'b1;
              end
            end
          end
        end
        jst_pkg::M_NUMBER: begin
          if (!eos && jst_pkg::is_num_char(data_byte)) begin
            res_valid = 1'b1;
            res.rk = jst_pkg::RK_PAYLOAD;
            res.tk = jst_pkg::TK_NUMBER;
            res.pay = data_byte;
          end else if (!(!eos && data_byte == " ")) begin
            mode_next = jst_pkg::M_BETWEEN;
            do_between = 1'b1;
          end
        end
        default: begin
          mode_next = jst_pkg::M_BETWEEN;
          do_between = 1'b1;
        end
      endcase

      if (do_between) begin
        if (eos) begin
          if (depth != '0) begin
            do_err = 1'b1;
            err_code = jst_pkg::ERR_UNCLOSED;
          end else begin
            res_valid = 1'b1;
            res.rk = jst_pkg::RK_OK;
            doc_rst = 1'b1;
          end
        end else begin
          unique case (data_byte)
            "{", "[": begin
              if (depth >= jst_pkg::DEPTH_FULL) begin
                do_err = 1'b1;
                err_code = jst_pkg::ERR_DEEP;
              end else begin
                push = 1'b1;
                depth_next = depth + 1'b1;
                res_valid = 1'b1;
                res.rk = jst_pkg::RK_TOKEN;
                res.tk = (data_byte == "{") ? jst_pkg::TK_OBJ_OPEN : jst_pkg::TK_ARR_OPEN;
                res.pos = counter;
                if (counter != jst_pkg::IDX_MAX) counter_next = counter + 1'b1;
              end
            end
            "}", "]": begin
              if (depth == '0) begin
                do_err = 1'b1;
                err_code = jst_pkg::ERR_UNBAL;
              end else begin
                pop = 1'b1;
                depth_next = depth - 1'b1;
                res_valid = 1'b1;
                res.rk = jst_pkg::RK_TOKEN;
                res.tk = (data_byte == "}") ? jst_pkg::TK_OBJ_CLOSE : jst_pkg::TK_ARR_CLOSE;
                res.pos = counter;
                res.close = 1'b1;
                if (counter != jst_pkg::IDX_MAX) counter_next = counter + 1'b1;
              end
            end
            ":", ",", " ", 8'h0a, 8'h0d: begin
            end
            "\"": begin
              res_valid = 1'b1;
              res.rk = jst_pkg::RK_TOKEN;
              res.tk = jst_pkg::TK_STRING;
              res.pos = counter;
              if (counter != jst_pkg::IDX_MAX) counter_next = counter + 1'b1;
              mode_next = jst_pkg::M_STRING;
            end
            "t", "f", "n": begin
              lit_kind_next = (data_byte == "t") ? 2'd0 : (data_byte == "f") ? 2'd1 : 2'd2;
              lit_count_next = 3'd1;
              lit_bad_next = 1'b0;
              mode_next = jst_pkg::M_LITERAL;
            end
            default: begin
              if ((data_byte >= "0" && data_byte <= "9") || data_byte == "-") begin
                res_valid = 1'b1;
                res.rk = jst_pkg::RK_TOKEN;
                res.tk = jst_pkg::TK_NUMBER;
                res.pay = data_byte;
                res.pos = counter;
                res.two = 1'b1;
                if (counter != jst_pkg::IDX_MAX) counter_next = counter + 1'b1;
                mode_next = jst_pkg::M_NUMBER;
              end else begin
                do_err = 1'b1;
                err_code = jst_pkg::ERR_BAD_CHAR;
              end
            end
          endcase
        end
      end

      if (do_err) begin
        res = '0;
        res_valid = 1'b1;
        res.rk = jst_pkg::RK_ERROR;
        res.err = err_code;
        mode_next = jst_pkg::M_BETWEEN;
        draining_next = 1'b1;
        doc_rst = eos;
      end
    end

    if (doc_rst) begin
      mode_next = jst_pkg::M_BETWEEN;
      lit_kind_next = 2'd0;
      lit_count_next = 3'd0;
      lit_bad_next = 1'b0;
      hex_count_next = 3'd0;
      counter_next = '0;
      depth_next = '0;
      draining_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jst_pkg::M_BETWEEN;
      lit_kind <= 2'd0;
      lit_count <= 3'd0;
      lit_bad <= 1'b0;
      hex_count <= 3'd0;
      counter <= '0;
      depth <= '0;
      draining <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      lit_kind <= lit_kind_next;
      lit_count <= lit_count_next;
      lit_bad <= lit_bad_next;
      hex_count <= hex_count_next;
      counter <= counter_next;
      depth <= depth_next;
      draining <= draining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push) stack_mem[wr_addr] <= counter;
    if (accept && pop) rd_data <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      phase <= 1'b0;
    end else if (accept) begin
      job_valid <= res_valid;
      phase <= 1'b0;
    end else if (job_done) begin
      job_valid <= 1'b0;
      phase <= 1'b0;
    end else if (job_valid && !out_stall) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) job <= res;
  end

  assign span_raw = (job.pos >= rd_data) ?
                    ({1'b0, job.pos} - {1'b0, rd_data} + 1'b1) : '0;

  assign out_valid = job_valid;
  assign record_kind = phase ? jst_pkg::RK_PAYLOAD : job.rk;
  assign token_kind = phase ? jst_pkg::TK_NUMBER : job.tk;
  assign payload_byte = (job.two && !phase) ? 8'h00 : job.pay;
  assign token_position = phase ? '0 : job.pos;
  assign opener_position = (job.close && !phase) ? rd_data : '0;
  assign span_length = (!job.close || phase) ? '0 :
                       span_raw[jst_pkg::IW] ? jst_pkg::IDX_MAX : span_raw[jst_pkg::IW-1:0];
  assign error_code = phase ? jst_pkg::ERR_NONE : job.err;
  assign last_of_run = !job.two || phase;

endmodule

// ===== rtl/core/jst_checker.sv =====
// Port-level checks for the JSON stream tokenizer, bound to the top level.
module jst_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [7:0]            data_byte,
  input logic                  end_of_stream,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            record_kind,
  input logic [3:0]            token_kind,
  input logic [7:0]            payload_byte,
  input logic [jst_pkg::IW-1:0] token_position,
  input logic [jst_pkg::IW-1:0] opener_position,
  input logic [jst_pkg::IW-1:0] span_length,
  input logic [2:0]            error_code,
  input logic                  last_of_run
);

  // input backs up only behind a waiting record
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no record pending");

  // a record that is not last of its run is followed by the number payload
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=>
      out_valid && record_kind == jst_pkg::RK_PAYLOAD && token_kind == jst_pkg::TK_NUMBER)
    else $error("first record of a pair not followed by its payload");

  a_opener_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_kind == jst_pkg::RK_TOKEN &&
      (token_kind == jst_pkg::TK_OBJ_CLOSE || token_kind == jst_pkg::TK_ARR_CLOSE) |->
      opener_position <= token_position && span_length != '0)
    else $error("close token opener after close index");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(record_kind) && $stable(token_kind) &&
      $stable(payload_byte) && $stable(token_position) && $stable(span_length) &&
      $stable(error_code) && $stable(last_of_run))
    else $error("stalled record changed");

endmodule

bind json_stream_tokenizer jst_checker u_jst_checker (.*);
